>>> design/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared constants and helpers for integer_to_ascii_digits
// Radix codes, digit buffer sizes, the double-dabble step and the digit to
// ASCII mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // input value width and default number of bits actually converted
  localparam int VALUE_W        = 32;
  localparam int VALUE_BITS_DEF = 32;

  // radix select codes
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // digit buffer: ten decimal digits cover a 32-bit value, hex uses eight
  localparam int DIGIT_NUM = 10;
  localparam int DIGIT_W   = 4;
  localparam int BCD_W     = DIGIT_NUM * DIGIT_W;
  localparam int IDX_W     = 4;

  // output character
  localparam int              CHAR_W     = 7;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_F    = 7'h46;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;

  // digit buffer type, least significant digit at index 0
  typedef logic [DIGIT_NUM-1:0][DIGIT_W-1:0] digits_t;

  // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGIT_NUM; i++) begin
      if (adj[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = adj[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // digit 0..15 to '0'..'9' or 'A'..'F'
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d <= 4'd9) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_A + (dx - 7'd10);
  endfunction

endpackage

>>> design/integer_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: unsigned binary to ASCII decimal or hex digits
// Pipelined double-dabble (decimal) or nibble split (hex), then a character
// serializer that sends the digits most significant first, leading zeros suppressed.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------
//  input     | start / busy       | value[31:0], opcode
//  result    | strobe (no stall)  | digit_char[6:0], last
//
// An item converts in ceil(VALUE_BITS/4) pipeline stages of four dabble steps
// each, plus an input register and a digit count stage; its first character
// reaches the ports from the serializer register, which the count stage loads.
// The serializer sends one character per cycle, so an item occupies it until
// the last of its digits, one to ten of them, is out; that sets the sustained rate.
// busy rises when every stage holds an item and the serializer is not on its
// last character. Synchronous reset clears only the valid bits.
//
module integer_to_ascii_digits #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [i2a_pkg::VALUE_W-1:0]  value,
  input  logic                         opcode,
  output logic                         strobe,
  output logic [i2a_pkg::CHAR_W-1:0]   digit_char,
  output logic                         last
);
  import i2a_pkg::*;

  localparam int StageBits = 4;
  localparam int NumStages = (VALUE_BITS + StageBits - 1) / StageBits;
  localparam int PadBits   = NumStages * StageBits;

  // conversion pipeline, stage 0 is the input register
  logic [NumStages:0] pv;
  logic [NumStages:0] pop;
  logic [NumStages:0] prdy;
  logic [PadBits-1:0] pval [0:NumStages];
  logic [BCD_W-1:0]   pbcd [0:NumStages];
  logic [BCD_W-1:0]   bcd_next [1:NumStages];

  // digit count stage
  logic               cv;
  logic               crdy;
  digits_t            cdig;
  logic [IDX_W-1:0]   cmsd;
  digits_t            cdig_next;
  logic [IDX_W-1:0]   cmsd_next;

  // character serializer
  logic               sv;
  logic               ser_free;
  digits_t            sdig;
  logic [IDX_W-1:0]   sidx;

  // ready chain, back from the serializer
  always_comb begin
    ser_free = !sv || (sidx == '0);
    crdy     = !cv || ser_free;
    prdy[NumStages] = !pv[NumStages] || crdy;
    for (int k = NumStages - 1; k >= 0; k--) begin
      prdy[k] = !pv[k] || prdy[k+1];
    end
  end

  assign busy = !prdy[0];

  // four dabble steps per stage, on the next nibble of the value
  always_comb begin
    for (int k = 1; k <= NumStages; k++) begin
      logic [BCD_W-1:0] b;
      b = pbcd[k-1];
      for (int j = 0; j < StageBits; j++) begin
        b = dabble_step(b, pval[k-1][PadBits-1-StageBits*(k-1)-j]);
      end
      bcd_next[k] = b;
    end
  end

  // input register and conversion stages
  always_ff @(posedge clk) begin
    if (prdy[0]) begin
      pval[0] <= PadBits'(value[VALUE_BITS-1:0]);
      pop[0]  <= opcode;
      pbcd[0] <= '0;
    end
    for (int k = 1; k <= NumStages; k++) begin
      if (prdy[k]) begin
        pval[k] <= pval[k-1];
        pop[k]  <= pop[k-1];
        pbcd[k] <= bcd_next[k];
      end
    end
    if (rst) begin
      pv <= '0;
    end else begin
      if (prdy[0]) begin
        pv[0] <= start;
      end
      for (int k = 1; k <= NumStages; k++) begin
        if (prdy[k]) begin
          pv[k] <= pv[k-1];
        end
      end
    end
  end

  // pick the digit set and find the most significant nonzero digit
  always_comb begin
    if (pop[NumStages] == OP_HEX) begin
      cdig_next = digits_t'(BCD_W'(pval[NumStages]));
    end else begin
      cdig_next = digits_t'(pbcd[NumStages]);
    end
    cmsd_next = '0;
    for (int i = 1; i < DIGIT_NUM; i++) begin
      if (cdig_next[i] != '0) begin
        cmsd_next = IDX_W'(i);
      end
    end
  end

  // count stage register
  always_ff @(posedge clk) begin
    if (crdy) begin
      cdig <= cdig_next;
      cmsd <= cmsd_next;
    end
    if (rst) begin
      cv <= 1'b0;
    end else if (crdy) begin
      cv <= pv[NumStages];
    end
  end

  // serializer, counts the digit index down to zero
  always_ff @(posedge clk) begin
    if (ser_free) begin
      sdig <= cdig;
      sidx <= cmsd;
    end else begin
      sidx <= sidx - 1'b1;
    end
    if (rst) begin
      sv <= 1'b0;
    end else if (ser_free) begin
      sv <= cv;
    end
  end

  // result ports
  assign strobe     = sv;
  assign digit_char = to_ascii(sdig[sidx]);
  assign last       = sv && (sidx == '0);

  // a run never breaks before its last character
  assert property (@(posedge clk) disable iff (rst) (strobe && !last) |=> strobe)
    else $error("character run broken before last");

  // an accepted item lands in the input register
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> pv[0])
    else $error("accepted item lost at input register");

  // back-pressure only comes from an occupied serializer
  assert property (@(posedge clk) disable iff (rst) busy |-> (sv && cv))
    else $error("busy without a full pipeline");

  // every character sent is a valid digit
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE) ||
                (digit_char >= ASCII_A && digit_char <= ASCII_F)))
    else $error("character out of digit range");

endmodule

>>> test/integer_to_ascii_digits_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_checker: digit stream checker
// Watches the input and result channels of integer_to_ascii_digits, builds
// the expected digit characters for every accepted item and compares each
// strobed character and its last flag against the oldest expectation.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_checker #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [i2a_pkg::VALUE_W-1:0] value,
  input  logic                        opcode,
  input  logic                        strobe,
  input  logic [i2a_pkg::CHAR_W-1:0]  digit_char,
  input  logic                        last,
  output int                          pending,
  output int                          failures
);
  import i2a_pkg::*;

  localparam logic [63:0] VALUE_MASK = (64'd1 << VALUE_BITS) - 64'd1;
  localparam int          PRINT_CAP  = 30;

  // one expected character, tagged with the item it came from
  typedef struct packed {
    logic [VALUE_W-1:0] src;
    logic               op;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
  } char_exp_t;

  char_exp_t expected_chars[$];

  task automatic report_mismatch(input string msg);
    if (failures < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    failures++;
  endtask

  // split the item into digits, most significant first, zeros suppressed
  function automatic void predict_chars(input logic [VALUE_W-1:0] raw, input logic op);
    logic [63:0] rest;
    logic [63:0] radix;
    logic [DIGIT_W-1:0] digs [DIGIT_NUM];
    logic [CHAR_W-1:0] dx;
    char_exp_t e;
    int n;
    rest  = {32'd0, raw} & VALUE_MASK;
    radix = (op == OP_HEX) ? 64'd16 : 64'd10;
    n     = 0;
    do begin
      digs[n] = DIGIT_W'(rest % radix);
      rest    = rest / radix;
      n++;
    end while (rest != 64'd0 && n < DIGIT_NUM);
    for (int k = n - 1; k >= 0; k--) begin
      dx           = {{(CHAR_W-DIGIT_W){1'b0}}, digs[k]};
      e.src        = raw;
      e.op         = op;
      e.digit_char = (digs[k] <= 4'd9) ? ASCII_ZERO + dx : ASCII_A + dx - 7'd10;
      e.last       = (k == 0);
      expected_chars.push_back(e);
    end
  endfunction

  // compare strobed characters first, then queue up a newly accepted item
  always @(posedge clk) begin : watch
    char_exp_t want;
    if (!rst) begin
      if (strobe) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("character 0x%0h last=%0b with no item pending",
                                    digit_char, last));
        end else begin
          want = expected_chars.pop_front();
          if (digit_char !== want.digit_char) begin
            report_mismatch($sformatf("value 0x%08h op %0b: digit_char 0x%0h, want 0x%0h",
                                      want.src, want.op, digit_char, want.digit_char));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("value 0x%08h op %0b: last %0b, want %0b",
                                      want.src, want.op, last, want.last));
          end
        end
      end
      if (start && !busy) begin
        predict_chars(value, opcode);
      end
    end
    pending <= expected_chars.size();
  end

endmodule

>>> test/integer_to_ascii_digits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_tb: testbench for integer_to_ascii_digits
// Drives directed and random values in both radixes with random sender gaps,
// lets the checker predict and compare the digit stream, and reports the
// verdict once every expected character has come out.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_tb;
  import i2a_pkg::*;

  localparam int VB           = VALUE_BITS_DEF;
  localparam int ITEMS_PHASE  = 33;
  localparam int SETTLE       = (VB + 3) / 4 + 12;
  localparam int CYCLE_LIMIT  = 100000;

  logic               clk;
  logic               rst    = 1'b1;
  logic               start  = 1'b0;
  logic [VALUE_W-1:0] value  = '0;
  logic               opcode = OP_DEC;
  logic               busy;
  logic               strobe;
  logic [CHAR_W-1:0]  digit_char;
  logic               last;
  int                 pending;
  int                 failures;
  int                 cycles = 0;

  integer_to_ascii_digits #(.VALUE_BITS(VB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .opcode(opcode), .strobe(strobe), .digit_char(digit_char), .last(last)
  );

  integer_to_ascii_digits_checker #(.VALUE_BITS(VB)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .opcode(opcode), .strobe(strobe), .digit_char(digit_char), .last(last),
    .pending(pending), .failures(failures)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** integer_to_ascii_digits: FAILED **");
      $finish;
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [VALUE_W-1:0] v, input logic op);
    start  <= 1'b1;
    value  <= v;
    opcode <= op;
    do @(posedge clk); while (busy);
  endtask

  // random gap after an item; inputs wander while start is low
  task automatic sender_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start  <= 1'b0;
      value  <= $urandom;
      opcode <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
  endtask

  // hold off until every expected character has arrived
  task automatic drain_chars();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // values spread over all digit counts, with radix boundaries
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p;
    p = 32'd1;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return p - $urandom_range(0, 1);
      end
      default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    endcase
  endfunction

  initial begin : stimulus
    int sender_idle_pct;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, single digits, radix edges, full length runs
    send_item(32'd0, OP_DEC);
    send_item(32'd0, OP_HEX);
    send_item(32'd1, OP_DEC);
    send_item(32'd9, OP_DEC);
    send_item(32'd10, OP_DEC);
    send_item(32'd15, OP_HEX);
    send_item(32'd16, OP_HEX);
    send_item(32'd10, OP_HEX);
    send_item(32'd999999999, OP_DEC);
    send_item(32'd1000000000, OP_DEC);
    send_item(32'hFFFF_FFFF, OP_DEC);
    send_item(32'hFFFF_FFFF, OP_HEX);
    send_item(32'h8000_0000, OP_DEC);
    send_item(32'h8000_0000, OP_HEX);
    send_item(32'h0FFF_FFFF, OP_HEX);
    send_item(32'h1000_0000, OP_HEX);
    send_item(32'hABCD_EF01, OP_HEX);
    send_item(32'h1234_5678, OP_HEX);
    send_item(32'd4000000000, OP_DEC);
    send_item(32'd100, OP_DEC);
    sender_gap(50);
    send_item(32'h5555_5555, OP_DEC);
    send_item(32'hAAAA_AAAA, OP_HEX);
    drain_chars();

    // random: busy sender, then a sparse one, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 64 : 0;
      for (int i = 0; i < ITEMS_PHASE; i++) begin
        send_item(pick_value(), 1'($urandom_range(0, 1)));
        sender_gap(sender_idle_pct);
      end
      drain_chars();
    end

    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("** integer_to_ascii_digits: PASSED **");
    end else begin
      $display("** integer_to_ascii_digits: FAILED **");
    end
    $finish;
  end

endmodule
